// ----- design/stbs_pkg.sv -----
// ---------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search core.
// ---------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

    // default storage shape
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ENTRY_WIDTH_DEF = 32;

    // fixed field widths
    localparam int LEN_W     = 11;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 10;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    // result handed from the search engine to the output stage
    typedef struct packed
    {
        logic             valid;
        logic             found;
        logic [POS_W-1:0] position;
    } res_t;

endpackage

`default_nettype wire

// ----- design/stbs_ram.sv -----
// ---------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/stbs_engine.sv -----
// ---------------------------------------------------------------------------
// stbs_engine
// Binary search sequencer: one table probe per cycle against the RAM.
// ---------------------------------------------------------------------------
`default_nettype none

module stbs_engine #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [ENTRY_WIDTH-1:0]         key,
    input  wire logic [stbs_pkg::LEN_W-1:0]     table_len,
    input  wire logic [ENTRY_WIDTH-1:0]         rd_data,
    output logic                                rd_en,
    output logic      [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output logic                                busy,
    output stbs_pkg::res_t                      res,
    input  wire logic                           res_taken
);

    import stbs_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = AW + 1;
    localparam int LW  = (CW > LEN_W) ? CW : LEN_W;
    localparam int PXW = (AW > POS_W) ? AW : POS_W;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          low_reg, low_next;
    logic [CW-1:0]          hi_reg, hi_next;      // exclusive upper bound
    logic [AW-1:0]          mid_reg, mid_next;
    logic [ENTRY_WIDTH-1:0] key_reg, key_next;
    logic                   found_reg, found_next;
    logic [POS_W-1:0]       pos_reg, pos_next;

    logic [LW-1:0]  len_x;
    logic [CW-1:0]  n_sat;
    logic [CW-1:0]  n_m1;
    logic [AW-1:0]  mid0;
    logic           hit;
    logic           gt;
    logic [CW-1:0]  low_p;
    logic [CW-1:0]  hi_p;
    logic           empty;
    logic [CW:0]    sum_p;
    logic [AW-1:0]  mid_p;
    logic [PXW-1:0] mid_x;
    logic [POS_W-1:0] mid_pos;
    logic           finish;

    // saturate length and pick the first midpoint
    always_comb
    begin
        len_x = LW'(table_len);
        if (len_x > LW'(TABLE_DEPTH))
        begin
            n_sat = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = len_x[CW-1:0];
        end
        n_m1 = n_sat - CW'(1);
        mid0 = n_m1[AW:1];
    end

    // narrow the range from the probed entry
    always_comb
    begin
        hit   = $signed(rd_data) == $signed(key_reg);
        gt    = $signed(rd_data) > $signed(key_reg);
        low_p = gt ? low_reg : (CW'(mid_reg) + CW'(1));
        hi_p  = gt ? CW'(mid_reg) : hi_reg;
        empty = low_p >= hi_p;
        sum_p = (CW+1)'(low_p) + (CW+1)'(hi_p) - (CW+1)'(1);
        mid_p = sum_p[AW:1];
        mid_x   = PXW'(mid_reg);
        mid_pos = mid_x[POS_W-1:0];
        finish  = hit || empty;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (n_sat == '0) ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (finish)
                begin
                    state_next = res_taken ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        low_next   = low_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    low_next   = '0;
                    hi_next    = n_sat;
                    mid_next   = mid0;
                    found_next = 1'b0;
                    pos_next   = '0;
                end
            end
            ST_PROBE:
            begin
                low_next   = low_p;
                hi_next    = hi_p;
                mid_next   = mid_p;
                found_next = hit;
                pos_next   = hit ? mid_pos : '0;
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rd_en        = 1'b0;
        rd_addr      = mid0;
        busy         = 1'b1;
        res.valid    = 1'b0;
        res.found    = found_reg;
        res.position = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                busy  = 1'b0;
                rd_en = start && (n_sat != '0);
            end
            ST_PROBE:
            begin
                rd_addr      = mid_p;
                rd_en        = !finish;
                res.valid    = finish;
                res.found    = hit;
                res.position = hit ? mid_pos : '0;
            end
            ST_DONE:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    // a probe always has a non-empty range
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> low_reg < hi_reg)
        else $error("probe with empty search range");

    // probed midpoint lies inside the range
    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> (CW'(mid_reg) >= low_reg) && (CW'(mid_reg) < hi_reg))
        else $error("midpoint outside search range");

    // reads only at search start or during probing
    a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ST_PROBE) || (state_reg == ST_IDLE && start))
        else $error("table read outside a search");

    // an untaken result is held unchanged
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res_taken |=> res.valid && $stable(res.found) && $stable(res.position))
        else $error("pending result dropped or changed");

endmodule

`default_nettype wire

// ----- design/sorted_table_binary_search_core.sv -----
// ---------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted table in RAM with a one-probe-per-cycle binary search.
// ---------------------------------------------------------------------------
//
//  channel   direction  words / fields (low bit first)
//  -------   ---------  ------------------------------------------------------
//  s_*       in         tuser: cmd (0 write, 1 search); tdata: entry_index[9:0],
//                       value[41:10], zero pad[47:42]
//  m_*       out        tuser: found; tdata: position[9:0], zero pad[15:10]
//  cfg_*     in         cfg_wr_data: table_len, written when cfg_wr_en is high
//
//  A write word gives no result. A search word runs P table probes, P at
//  most floor(log2(table_len)) + 1; the loop is bounded by the single RAM
//  read port, one entry per cycle. An empty table answers with no probe.
//  Reset clears the control state and table_len only; table entries stay
//  undefined until written, and no clearing pass is run.
//  A stalled m_tready holds the result register; one further search may
//  run and waits in the engine until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [stbs_pkg::S_TDATA_W-1:0]   s_tdata,  // entry_index, value, pad
    input  wire logic                             s_tuser,  // cmd
    // result words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [stbs_pkg::M_TDATA_W-1:0]   m_tdata,  // position, pad
    output logic                                  m_tuser,  // found
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [stbs_pkg::LEN_W-1:0]       cfg_wr_data
);

    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int XW = ((AW + 1) > INDEX_W) ? (AW + 1) : INDEX_W;

    logic [LEN_W-1:0] table_len_reg, table_len_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [POS_W-1:0] m_pos_reg, m_pos_next;

    logic [INDEX_W-1:0]     entry_index;
    logic [VALUE_W-1:0]     value;
    logic [63:0]            value_x;
    logic [ENTRY_WIDTH-1:0] entry;
    logic [XW-1:0]          index_x;
    logic                   in_fire;
    logic                   wr_en;
    logic                   start;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [ENTRY_WIDTH-1:0] rd_data;
    logic                   busy;
    res_t                   res;
    logic                   res_taken;

    // unpack the input word and fold the value to the entry width
    always_comb
    begin
        entry_index = s_tdata[INDEX_W-1:0];
        value       = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
        value_x     = {{(64-VALUE_W){value[VALUE_W-1]}}, value};
        entry       = value_x[ENTRY_WIDTH-1:0];
        index_x     = XW'(entry_index);
    end

    // take words only while no search is running
    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign start    = in_fire && (s_tuser == CMD_SEARCH);
    // drop writes beyond the table depth
    assign wr_en    = in_fire && (s_tuser == CMD_WRITE) && (index_x < XW'(TABLE_DEPTH));

    stbs_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (index_x[AW-1:0]),
        .wr_data (entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .key       (entry),
        .table_len (table_len_reg),
        .rd_data   (rd_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .busy      (busy),
        .res       (res),
        .res_taken (res_taken)
    );

    // result register: load when empty or being drained
    assign res_taken = res.valid && (!m_valid_reg || m_tready);

    always_comb
    begin
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        table_len_next = table_len_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (res_taken)
        begin
            m_valid_next = 1'b1;
            m_found_next = res.found;
            m_pos_next   = res.position;
        end
        if (cfg_wr_en)
        begin
            table_len_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            table_len_reg <= '0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            table_len_reg <= table_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_found_reg <= m_found_next;
        m_pos_reg   <= m_pos_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(M_TDATA_W-POS_W){1'b0}}, m_pos_reg};

    // a miss always reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_found_reg |-> m_pos_reg == '0)
        else $error("miss with nonzero position");

    // no input taken while a search is running
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_tready || !busy)
        else $error("input accepted during search");

    // a result is never loaded over a pending word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_taken |-> !m_valid_reg || m_tready)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stream-level test of the sorted-table binary search core. Load table
// entries through write words and issue search words. Predict each search
// result from a shadow copy of the table and of table_len. Check every
// result word in order. Throttle both stream sides at random.
// ---------------------------------------------------------------------------

module tb;

    import stbs_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT   = 1_000_000;
    // settle time that covers a write or search still in flight
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // one predicted search outcome
    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    // -----------------------------------------------------------------------
    // DUT connections. Drive every input to a known value from time zero.
    // -----------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // entry_index[9:0], value[41:10], pad
    logic                 s_tuser     = 1'b0; // cmd
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // position[9:0], pad
    logic                 m_tuser;            // found
    logic                 cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;

    // -----------------------------------------------------------------------
    // Shadow state of the block and the queue of predicted search results.
    // Entries are 32 bits wide, the same as the value field, so no narrowing
    // applies before a compare. The 10-bit index cannot exceed the depth.
    // -----------------------------------------------------------------------
    logic signed [VALUE_W-1:0] shadow_table [TABLE_DEPTH_DEF];
    logic [LEN_W-1:0]          shadow_len = '0;
    lookup_t                   pending_lookups [$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  gaps_on     = 1'b1;  // clear to run a stretch with no idle cycles

    sorted_table_binary_search_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // table_len saturates at the table depth
    function automatic int active_len();
        return (shadow_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(shadow_len);
    endfunction

    // Halve [0, len-1] on the floor midpoint until a hit or an empty range.
    // A miss reports position 0. An unsorted table takes the same probes.
    function automatic lookup_t bsearch_table(input logic signed [VALUE_W-1:0] key);
        lookup_t res;
        int      lo;
        int      hi;
        int      mid;
        res = '0;
        lo  = 0;
        hi  = active_len() - 1;
        while (lo <= hi && !res.found)
        begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == key)
            begin
                res.found    = 1'b1;
                res.position = mid[POS_W-1:0];
            end
            else if (shadow_table[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Idle-gap shaping: mostly none or short, a few long.
    // -----------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // -----------------------------------------------------------------------
    // Result side: throttle m_tready, then check each accepted word.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left == 0)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
    endtask

    // Sample at the edge: values read here are the ones the DUT saw.
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result word with no search pending (position)", 0,
                                m_tdata[POS_W-1:0]);
            else
            begin
                want = pending_lookups.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("found", want.found, m_tuser);
                if (m_tdata[POS_W-1:0] !== want.position)
                    report_mismatch("position", want.position, m_tdata[POS_W-1:0]);
                if (m_tdata[M_TDATA_W-1:POS_W] !== '0)
                    report_mismatch("tdata pad", 0, m_tdata[M_TDATA_W-1:POS_W]);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------

    // Send one word after a random gap; predict its effect once accepted.
    // tvalid stays high across back-to-back words.
    task automatic send_word(input cmd_t op, input logic [INDEX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-INDEX_W-VALUE_W){1'b0}}, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == CMD_WRITE)
            shadow_table[idx] = val;
        else
            pending_lookups.push_back(bsearch_table(val));
    endtask

    // Drop tvalid, wait for every pending result, then let a trailing write
    // or search finish inside the block.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write table_len, only with the block idle.
    task automatic set_table_len(input logic [LEN_W-1:0] len);
        wait_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_len   = len;
    endtask

    // Load entries 0..n-1 in ascending order. Dense runs repeat values often;
    // sparse runs spread toward the top of the signed range.
    task automatic write_sorted_run(input int n, input bit sparse);
        longint v;
        longint step_max;
        int     i;
        case ($urandom_range(0, 2))
            0:       v = longint'(KEY_MIN);
            1:       v = longint'(int'($urandom));
            default: v = longint'($urandom_range(0, 200)) - 100;
        endcase
        for (i = 0; i < n; i++)
        begin
            send_word(CMD_WRITE, i[INDEX_W-1:0], v[VALUE_W-1:0]);
            if (sparse)
            begin
                step_max = (longint'(KEY_MAX) - v) / (n - i);
                v += longint'($urandom_range(0, step_max[31:0]));
            end
            else
                v += longint'($urandom_range(0, 3));
            if (v > longint'(KEY_MAX))
                v = longint'(KEY_MAX);
        end
    endtask

    // Keys: mostly present entries, then near misses, random and extremes.
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int                        n;
        int                        r;
        int                        j;
        logic signed [VALUE_W-1:0] k;
        n = active_len();
        r = $urandom_range(0, 99);
        j = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (n > 0 && r < 55)
            k = shadow_table[j];
        else if (n > 0 && r < 75)
            k = shadow_table[j] + (r[0] ? 1 : -1);
        else if (r < 90)
            k = $urandom;
        else
        begin
            case (r % 4)
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                default: k = -1;
            endcase
        end
        return k;
    endfunction

    // Mostly searches; some stray writes anywhere (which may unsort the
    // active range) and an occasional hold until all results are back.
    task automatic run_searches(input int count);
        int i;
        int r;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                wait_until_idle();
            else if (r < 10)
                send_word(CMD_WRITE, INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)),
                          $urandom);
            else
                send_word(CMD_SEARCH, INDEX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)),
                          pick_key());
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Empty table after reset: every search misses. Also hit both index
    // extremes with write words.
    task automatic test_empty_table();
        send_word(CMD_SEARCH, '0, KEY_MIN);
        send_word(CMD_SEARCH, '1, '0);
        send_word(CMD_SEARCH, 10'h155, KEY_MAX);
        send_word(CMD_WRITE, '1, KEY_MAX);
        send_word(CMD_WRITE, '0, KEY_MIN);
    endtask

    // One entry: a hit at position 0 and misses above it.
    task automatic test_single_entry();
        set_table_len(1);
        send_word(CMD_SEARCH, 10'h2AA, KEY_MIN);
        send_word(CMD_SEARCH, '0, KEY_MAX);
        send_word(CMD_SEARCH, '1, '0);
    endtask

    // Four sorted entries from the most negative to the most positive value.
    task automatic test_sorted_edges();
        send_word(CMD_WRITE, 1, -1);
        send_word(CMD_WRITE, 2, 0);
        send_word(CMD_WRITE, 3, KEY_MAX);
        set_table_len(4);
        send_word(CMD_SEARCH, '0, KEY_MIN);
        send_word(CMD_SEARCH, '0, -1);
        send_word(CMD_SEARCH, '1, 0);
        send_word(CMD_SEARCH, '1, KEY_MAX);
        send_word(CMD_SEARCH, '0, 1);
        send_word(CMD_SEARCH, '0, -2);
    endtask

    // Break the order: present values can now be missed by the probes.
    task automatic test_unsorted_table();
        send_word(CMD_WRITE, 1, 500);
        send_word(CMD_WRITE, 3, -5);
        send_word(CMD_SEARCH, '0, -5);
        send_word(CMD_SEARCH, '0, 500);
        send_word(CMD_SEARCH, '0, 0);
    endtask

    // Many short tables, reloaded each round; some empty.
    task automatic test_random_short_tables();
        int round;
        int n;
        for (round = 0; round < 18; round++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
            set_table_len(LEN_W'(n));
            if (n > 0)
                write_sorted_run(n, ($urandom_range(0, 1) != 0));
            run_searches(27);
        end
    endtask

    // Fill the whole table, then search with table_len at the depth and
    // beyond it (saturates), and at a random length under it in the upper half.
    task automatic test_full_table();
        int round;
        gaps_on = 1'b1;
        write_sorted_run(TABLE_DEPTH_DEF, 1'b1);
        for (round = 0; round < 4; round++)
        begin
            gaps_on = (round != 2);
            case (round)
                0:       set_table_len(LEN_W'(TABLE_DEPTH_DEF));
                1:       set_table_len('1);
                2:       set_table_len(LEN_W'(TABLE_DEPTH_DEF + 1));
                default: set_table_len(LEN_W'($urandom_range(513, TABLE_DEPTH_DEF - 1)));
            endcase
            run_searches(40);
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence: reset once, run the tests, drain, report.
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_single_entry();
        test_sorted_edges();
        test_unsorted_table();
        test_random_short_tables();
        test_full_table();
        wait_until_idle();
        if (mismatches == 0)
            $display("[sorted_table_binary_search_core] OK");
        else
            $display("[sorted_table_binary_search_core] ERROR");
        $finish;
    end

    // Hard stop for a hung handshake.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sorted_table_binary_search_core] ERROR");
        $finish;
    end

endmodule
